// ===== sv/xcr_pkg.sv =====
package xcr_pkg;

  localparam int unsigned DataBytesDef = 128;
  localparam int unsigned SeqW = 26;

  localparam logic [7:0] RepC   = 8'h43;
  localparam logic [7:0] RepAck = 8'h06;
  localparam logic [7:0] RepNak = 8'h15;
  localparam logic [7:0] RepCan = 8'h18;
  localparam logic [7:0] HdrSoh = 8'h01;
  localparam logic [7:0] HdrEot = 8'h04;

  localparam logic OpStart = 1'b0;
  localparam logic OpByte  = 1'b1;

  localparam logic CfgBase   = 1'b0;
  localparam logic CfgRegion = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] write_address;
    logic [31:0] write_word;
    logic [7:0]  reply_code;
    logic        session_over;
    logic        last;
  } out_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/xcr_buffer.sv =====
module xcr_buffer #(
  parameter int unsigned DATA_BYTES = xcr_pkg::DataBytesDef
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DATA_BYTES)-1:0]     wr_addr,
  input  logic [7:0]                        wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(DATA_BYTES/4)-1:0]   rd_addr,
  output logic [31:0]                       rd_word
);
  localparam int unsigned Words = DATA_BYTES / 4;

  logic [31:0] mem [Words];
  logic [$clog2(Words)-1:0] waddr;

  assign waddr = wr_addr[$clog2(DATA_BYTES)-1:2];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_addr[1:0])
        2'd0: mem[waddr][7:0] <= wr_data;
        2'd1: mem[waddr][15:8] <= wr_data;
        2'd2: mem[waddr][23:16] <= wr_data;
        default: mem[waddr][31:24] <= wr_data;
      endcase
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end
endmodule

// ===== sv/xmodem_crc_receiver_top.sv =====
// A reply is registered and appears in the cycle after its request is accepted;
// an accepted packet then streams its word writes one per cycle while the output
// is not stalled, each word read from the buffer memory, then the ACK.
// Throughput: one frame byte per cycle while receiving and the output is free.
// Reset (synchronous, rst_n low) closes the session and clears the registers.
module xmodem_crc_receiver_top #(
  parameter int unsigned DATA_BYTES = xcr_pkg::DataBytesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xcr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xcr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import xcr_pkg::*;

  localparam int unsigned FrameLen = DATA_BYTES + 5;
  localparam int unsigned PosCap = DATA_BYTES + 6;
  localparam int unsigned PosW = $clog2(PosCap + 1);
  localparam int unsigned Words = DATA_BYTES / 4;
  localparam int unsigned WW = $clog2(Words);
  localparam int unsigned AW = $clog2(DATA_BYTES);
  localparam int unsigned ShW = $clog2(DATA_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WR   = 3'b010,
    ST_ACK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] base_r, region_r;
  logic active_r;
  logic [SeqW-1:0] seq_r;
  logic [PosW-1:0] pos_r;
  logic [7:0] hdr_r, num_r, cmp_r;
  logic [15:0] crc_r, rcrc_r;
  logic [WW-1:0] rd_cnt_r;
  logic rd_pend_r;
  logic [31:0] addr_r;
  logic [WW-1:0] wr_cnt_r;
  logic out_valid_r;
  out_item_t out_r;

  logic acc, out_free;
  logic [PosW-1:0] npos;
  logic buf_we, buf_re;
  logic [31:0] rd_word;
  logic [7:0] b;
  logic [7:0] nhdr, nnum, ncmp;
  logic [15:0] ncrc, nrcrc;
  logic [SeqW+ShW-1:0] need;
  logic frame_close, pkt_ok, out_set;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign b = in_data.frame_byte;

  always_comb begin
    nhdr = hdr_r; nnum = num_r; ncmp = cmp_r; ncrc = crc_r; nrcrc = rcrc_r;
    buf_we = 1'b0;
    if (pos_r == PosW'(0)) nhdr = b;
    else if (pos_r == PosW'(1)) nnum = b;
    else if (pos_r == PosW'(2)) ncmp = b;
    else if (pos_r < PosW'(DATA_BYTES + 3)) begin
      ncrc = crc_byte(crc_r, b);
      buf_we = acc && in_data.operation == OpByte && active_r;
    end else if (pos_r == PosW'(DATA_BYTES + 3)) nrcrc = {b, rcrc_r[7:0]};
    else if (pos_r == PosW'(DATA_BYTES + 4)) nrcrc = {rcrc_r[15:8], b};
    npos = (pos_r >= PosW'(PosCap)) ? PosW'(PosCap) : pos_r + PosW'(1);
    need = {seq_r, {ShW{1'b0}}};
  end

  assign frame_close = acc && in_data.operation == OpByte && active_r && in_data.frame_end;
  assign pkt_ok = (npos == PosW'(FrameLen)) && (9'(nnum) + 9'(ncmp) == 9'd255) &&
                  (crc_r == nrcrc) && (nhdr == HdrSoh) &&
                  !(need > (SeqW+ShW)'(region_r)) && (nnum == seq_r[7:0]);
  assign out_set = (acc && in_data.operation == OpStart) || (frame_close && !pkt_ok) ||
                   (rd_pend_r && out_free) ||
                   (state_r == ST_ACK && out_free && !rd_pend_r);

  logic [AW-1:0] wa;
  assign wa = AW'(pos_r - PosW'(3));
  assign buf_re = (state_r == ST_WR) && out_free;

  xcr_buffer #(.DATA_BYTES(DATA_BYTES)) u_buf (
    .clk(clk), .wr_en(buf_we), .wr_addr(wa), .wr_data(b),
    .rd_en(buf_re), .rd_addr(rd_cnt_r), .rd_word(rd_word)
  );

  function automatic out_item_t rep(input logic [7:0] c, input logic ov);
    out_item_t o;
    o = '0;
    o.kind = 1'b1; o.reply_code = c; o.session_over = ov; o.last = 1'b1;
    return o;
  endfunction

  function automatic out_item_t wr(input logic [31:0] a, input logic [31:0] w);
    out_item_t o;
    o = '0;
    o.write_address = a; o.write_word = w;
    return o;
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (frame_close && pkt_ok) state_nxt = ST_WR;
      ST_WR: if (buf_re && rd_cnt_r == WW'(Words - 1)) state_nxt = ST_ACK;
      ST_ACK: if (out_free && !rd_pend_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; base_r <= '0; region_r <= '0; active_r <= 1'b0;
      seq_r <= SeqW'(1); pos_r <= '0; hdr_r <= '0; num_r <= '0; cmp_r <= '0;
      crc_r <= '0; rcrc_r <= '0; out_valid_r <= 1'b0; rd_cnt_r <= '0;
      rd_pend_r <= 1'b0; wr_cnt_r <= '0; addr_r <= '0; out_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == CfgBase) base_r <= cfg_data;
        else region_r <= cfg_data;
      end
      out_valid_r <= out_set || (out_valid_r && out_stall);
      if (acc) begin
        if (in_data.operation == OpStart) begin
          active_r <= 1'b1; seq_r <= SeqW'(1); pos_r <= '0; crc_r <= '0;
          out_r <= rep(RepC, 1'b0);
        end else if (active_r) begin
          hdr_r <= nhdr; num_r <= nnum; cmp_r <= ncmp; rcrc_r <= nrcrc;
          if (!in_data.frame_end) begin
            pos_r <= npos; crc_r <= ncrc;
          end else begin
            pos_r <= '0; crc_r <= '0;
            if (npos == PosW'(1)) begin
              out_r <= rep((nhdr == HdrEot) ? RepAck : RepCan, 1'b1);
              active_r <= 1'b0;
            end else if (npos != PosW'(FrameLen)) begin
              out_r <= rep(RepCan, 1'b1); active_r <= 1'b0;
            end else if (9'(nnum) + 9'(ncmp) != 9'd255) out_r <= rep(RepNak, 1'b0);
            else if (crc_r != nrcrc) out_r <= rep(RepNak, 1'b0);
            else if (nhdr != HdrSoh) begin
              out_r <= rep(RepCan, 1'b1); active_r <= 1'b0;
            end else if (need > (SeqW+ShW)'(region_r)) begin
              out_r <= rep(RepCan, 1'b1); active_r <= 1'b0;
            end else if (nnum + 8'd1 == seq_r[7:0]) out_r <= rep(RepAck, 1'b0);
            else if (nnum != seq_r[7:0]) begin
              out_r <= rep(RepCan, 1'b1); active_r <= 1'b0;
            end else begin
              rd_cnt_r <= '0; wr_cnt_r <= '0;
              addr_r <= base_r + 32'({seq_r - SeqW'(1), {ShW{1'b0}}});
              seq_r <= seq_r + SeqW'(1);
            end
          end
        end
      end
      if (buf_re) rd_cnt_r <= rd_cnt_r + WW'(1);
      if (out_free) rd_pend_r <= buf_re;
      if (rd_pend_r && out_free) begin
        out_r <= wr(addr_r + 32'({wr_cnt_r, 2'b00}), rd_word);
        wr_cnt_r <= wr_cnt_r + WW'(1);
      end else if (state_r == ST_ACK && out_free && !rd_pend_r) begin
        out_r <= rep(RepAck, 1'b0);
      end
    end
  end
endmodule

// ===== verif/xmodem_crc_receiver_top_tb.sv =====
`timescale 1ns / 1ps

module xmodem_crc_receiver_top_tb;
  import xcr_pkg::*;

  localparam int unsigned NData = DataBytesDef;
  localparam int unsigned FullLen = NData + 5;
  localparam int unsigned CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CfgBase;
  logic [31:0] cfg_data = '0;

  xmodem_crc_receiver_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow state of the receiver.
  logic [31:0] base_addr_q;
  logic [31:0] region_q;
  logic sess_q;
  logic [SeqW-1:0] seq_q;
  int unsigned pos_q;
  logic [7:0] hdr_q, num_q, cmp_q;
  logic [15:0] crc_q, rx_crc_q;
  logic [7:0] buf_q [NData];

  out_item_t pending_q[$];
  out_item_t last_rep;
  int errors = 0;
  int unsigned cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  task automatic push_reply(logic [7:0] code, logic over);
    out_item_t r;
    r = '0;
    r.kind = 1'b1;
    r.reply_code = code;
    r.session_over = over;
    r.last = 1'b1;
    pending_q.push_back(r);
    last_rep = r;
    if (over) sess_q = 1'b0;
  endtask

  task automatic close_frame(int unsigned len);
    out_item_t r;
    logic [7:0] exp8;
    logic [31:0] start;
    exp8 = seq_q[7:0];
    if (len == 1) begin
      push_reply(hdr_q == HdrEot ? RepAck : RepCan, 1'b1);
    end else if (len != FullLen) begin
      push_reply(RepCan, 1'b1);
    end else if ({1'b0, num_q} + {1'b0, cmp_q} != 9'd255) begin
      push_reply(RepNak, 1'b0);
    end else if (crc_q != rx_crc_q) begin
      push_reply(RepNak, 1'b0);
    end else if (hdr_q != HdrSoh) begin
      push_reply(RepCan, 1'b1);
    end else if (64'(seq_q) * NData > 64'(region_q)) begin
      push_reply(RepCan, 1'b1);
    end else if (num_q + 8'd1 == exp8) begin
      push_reply(RepAck, 1'b0);
    end else if (num_q != exp8) begin
      push_reply(RepCan, 1'b1);
    end else begin
      start = base_addr_q + 32'(SeqW'(seq_q - SeqW'(1))) * 32'(NData);
      for (int i = 0; i < NData / 4; i++) begin
        r = '0;
        r.write_address = start + 32'(4 * i);
        r.write_word = {buf_q[4*i+3], buf_q[4*i+2], buf_q[4*i+1], buf_q[4*i]};
        pending_q.push_back(r);
      end
      seq_q = seq_q + 1'b1;
      push_reply(RepAck, 1'b0);
    end
  endtask

  task automatic predict(in_item_t it);
    int unsigned p;
    if (it.operation == OpStart) begin
      sess_q = 1'b1;
      seq_q = 1;
      pos_q = 0;
      crc_q = '0;
      push_reply(RepC, 1'b0);
      return;
    end
    if (!sess_q) return;
    p = pos_q;
    if (p == 0) hdr_q = it.frame_byte;
    else if (p == 1) num_q = it.frame_byte;
    else if (p == 2) cmp_q = it.frame_byte;
    else if (p < 3 + NData) begin
      buf_q[p-3] = it.frame_byte;
      crc_q = crc_step(crc_q, it.frame_byte);
    end else if (p == 3 + NData) rx_crc_q[15:8] = it.frame_byte;
    else if (p == 4 + NData) rx_crc_q[7:0] = it.frame_byte;
    p++;
    if (p > NData + 6) p = NData + 6;
    if (!it.frame_end) begin
      pos_q = p;
      return;
    end
    pos_q = 0;
    close_frame(p);
    crc_q = '0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result %p", out_data);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_data.kind !== e.kind) begin
          $error("kind exp %0h got %0h", e.kind, out_data.kind); errors++;
        end
        if (out_data.write_address !== e.write_address) begin
          $error("write_address exp %0h got %0h", e.write_address,
                 out_data.write_address); errors++;
        end
        if (out_data.write_word !== e.write_word) begin
          $error("write_word exp %0h got %0h", e.write_word, out_data.write_word);
          errors++;
        end
        if (out_data.reply_code !== e.reply_code) begin
          $error("reply_code exp %0h got %0h", e.reply_code, out_data.reply_code);
          errors++;
        end
        if (out_data.session_over !== e.session_over) begin
          $error("session_over exp %0h got %0h", e.session_over,
                 out_data.session_over); errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last exp %0h got %0h", e.last, out_data.last); errors++;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int unsigned mode;
    forever begin
      if (hold_off) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  in_item_t stim_q[$];
  int burst_left = 0;

  task automatic send(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= it;
    predict(it);
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic idle_wait();
    int unsigned guard;
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (NData / 4 + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgBase) base_addr_q = val;
    else region_q = val;
    @(posedge clk);
  endtask

  function automatic in_item_t mk(logic op, logic [7:0] b, logic e);
    in_item_t it;
    it.operation = op;
    it.frame_byte = b;
    it.frame_end = e;
    return it;
  endfunction

  // Queues a frame; flaw selects damage: 0 clean, 1 complement, 2 CRC,
  // 3 header, 4 short, 5 overlong.
  task automatic queue_frame(logic [7:0] num, int flaw, int fill);
    logic [7:0] d [NData];
    logic [15:0] c;
    int n;
    c = '0;
    for (int i = 0; i < NData; i++) begin
      d[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : 8'($urandom);
      c = crc_step(c, d[i]);
    end
    if (flaw == 2) c = c ^ 16'(1 << $urandom_range(0, 15));
    stim_q.push_back(mk(OpByte, flaw == 3 ? 8'h02 : HdrSoh, 1'b0));
    stim_q.push_back(mk(OpByte, num, 1'b0));
    stim_q.push_back(mk(OpByte, flaw == 1 ? num : ~num, 1'b0));
    n = (flaw == 4) ? $urandom_range(0, NData - 1) : NData;
    for (int i = 0; i < n; i++) stim_q.push_back(mk(OpByte, d[i], 1'b0));
    stim_q.push_back(mk(OpByte, c[15:8], 1'b0));
    if (flaw == 5) begin
      stim_q.push_back(mk(OpByte, c[7:0], 1'b0));
      repeat ($urandom_range(1, 3)) stim_q.push_back(mk(OpByte, 8'($urandom), 1'b0));
    end
    stim_q.push_back(mk(OpByte, c[7:0], 1'b1));
  endtask

  task automatic run_queue();
    while (stim_q.size() != 0) send(stim_q.pop_front());
  endtask

  typedef struct {
    in_item_t it;
    bit check;
    logic [7:0] code;
    logic over;
  } row_t;

  initial begin
    row_t rows[$];
    int unsigned k;
    base_addr_q = '0;
    region_q = '0;
    sess_q = 1'b0;
    seq_q = 1;
    pos_q = 0;
    hdr_q = '0; num_q = '0; cmp_q = '0; crc_q = '0; rx_crc_q = '0;
    last_rep = '0;
    for (int i = 0; i < NData; i++) buf_q[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: no session, start, EOT, one-byte cancel, short frame.
    rows.push_back('{mk(OpByte, 8'hff, 1'b1), 1'b0, 8'h00, 1'b0});
    rows.push_back('{mk(OpStart, 8'h00, 1'b0), 1'b1, RepC, 1'b0});
    rows.push_back('{mk(OpByte, HdrEot, 1'b1), 1'b1, RepAck, 1'b1});
    rows.push_back('{mk(OpStart, 8'hff, 1'b1), 1'b1, RepC, 1'b0});
    rows.push_back('{mk(OpByte, 8'hff, 1'b1), 1'b1, RepCan, 1'b1});
    rows.push_back('{mk(OpStart, 8'h00, 1'b0), 1'b1, RepC, 1'b0});
    rows.push_back('{mk(OpByte, HdrSoh, 1'b0), 1'b0, 8'h00, 1'b0});
    rows.push_back('{mk(OpByte, 8'h01, 1'b1), 1'b1, RepCan, 1'b1});
    rows.push_back('{mk(OpStart, 8'h00, 1'b0), 1'b1, RepC, 1'b0});
    foreach (rows[i]) begin
      send(rows[i].it);
      if (rows[i].check) begin
        if (last_rep.reply_code != rows[i].code) begin
          $error("reply_code exp %0h got %0h", rows[i].code, last_rep.reply_code);
          errors++;
        end
        if (last_rep.session_over != rows[i].over) begin
          $error("session_over exp %0h got %0h", rows[i].over,
                 last_rep.session_over);
          errors++;
        end
      end
    end
    idle_wait();

    // The long hold-off fills the block while a clean packet arrives; the
    // word addresses wrap past the top of the address space.
    write_reg(CfgBase, 32'hffff_ffc0);
    write_reg(CfgRegion, 32'hffff_ffff);
    hold_off = 1'b1;
    stim_q.push_back(mk(OpStart, 8'h00, 1'b0));
    queue_frame(8'd1, 0, 2);
    run_queue();
    idle_wait();

    // Random noise: restarts, one-byte frames and short frames.
    for (int n = 0; n < 60; n++) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        stim_q.push_back(mk(OpStart, 8'($urandom), 1'($urandom)));
      end else if (k == 1) begin
        stim_q.push_back(mk(OpByte, HdrEot, 1'b1));
      end else begin
        stim_q.push_back(mk(OpByte, 8'($urandom), 1'($urandom_range(0, 3) == 0)));
      end
    end
    run_queue();
    idle_wait();

    if (errors == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
